@@ src/rmq_pkg.sv @@
package rmq_pkg;

  localparam int MW = 16;
  localparam int TW = 19;
  localparam int SW = 18;
  localparam int NW = 30;
  localparam int RW = NW / 2;
  localparam int QW = 17;
  localparam int DW = NW;
  localparam int LAT = 1 + RW + 1 + QW + 1;

  localparam logic [1:0] PIV_X = 2'd0;
  localparam logic [1:0] PIV_Y = 2'd1;
  localparam logic [1:0] PIV_Z = 2'd2;
  localparam logic [1:0] PIV_W = 2'd3;

  typedef struct packed {
    logic signed [MW-1:0] m00;
    logic signed [MW-1:0] m01;
    logic signed [MW-1:0] m02;
    logic signed [MW-1:0] m10;
    logic signed [MW-1:0] m11;
    logic signed [MW-1:0] m12;
    logic signed [MW-1:0] m20;
    logic signed [MW-1:0] m21;
    logic signed [MW-1:0] m22;
  } rmq_req_t;

  typedef struct packed {
    logic signed [MW-1:0] qx;
    logic signed [MW-1:0] qy;
    logic signed [MW-1:0] qz;
    logic signed [MW-1:0] qw;
    logic [1:0]           pivot;
    logic                 degenerate;
  } rmq_res_t;

  typedef struct packed {
    logic [1:0]           pivot;
    logic                 degenerate;
    logic signed [SW-1:0] sa;
    logic signed [SW-1:0] sb;
    logic signed [SW-1:0] sc;
  } rmq_side_t;

  typedef struct packed {
    logic [1:0]           pivot;
    logic                 degenerate;
    logic [MW-1:0]        v;
    logic signed [MW-1:0] qa;
    logic signed [MW-1:0] qb;
    logic signed [MW-1:0] qc;
  } rmq_dres_t;

endpackage

@@ src/rmq_pivot.sv @@
module rmq_pivot (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  rmq_pkg::rmq_req_t  req,
  output logic               out_vld,
  output logic [rmq_pkg::NW-1:0] n,
  output rmq_pkg::rmq_side_t side
);
  import rmq_pkg::*;

  logic signed [TW-1:0] t0, t1, t2, t3, tp;
  logic [1:0] p;
  logic signed [SW-1:0] s01p, s20p, s12p, s12m, s20m, s01m;
  rmq_side_t side_next;
  logic [NW-1:0] n_next;

  always_comb begin
    t0 = TW'(req.m00) - TW'(req.m11) - TW'(req.m22) + TW'(16384);
    t1 = -TW'(req.m00) + TW'(req.m11) - TW'(req.m22) + TW'(16384);
    t2 = -TW'(req.m00) - TW'(req.m11) + TW'(req.m22) + TW'(16384);
    t3 = TW'(req.m00) + TW'(req.m11) + TW'(req.m22) + TW'(16384);
    p = PIV_X;
    tp = t0;
    if (t1 > tp) begin
      p = PIV_Y;
      tp = t1;
    end
    if (t2 > tp) begin
      p = PIV_Z;
      tp = t2;
    end
    if (t3 > tp) begin
      p = PIV_W;
      tp = t3;
    end
    s01p = SW'(req.m01) + SW'(req.m10);
    s20p = SW'(req.m20) + SW'(req.m02);
    s12p = SW'(req.m12) + SW'(req.m21);
    s12m = SW'(req.m12) - SW'(req.m21);
    s20m = SW'(req.m20) - SW'(req.m02);
    s01m = SW'(req.m01) - SW'(req.m10);
    side_next.pivot = p;
    side_next.degenerate = tp[TW-1];
    unique case (p)
      PIV_X: begin
        side_next.sa = s01p;
        side_next.sb = s20p;
        side_next.sc = s12m;
      end
      PIV_Y: begin
        side_next.sa = s01p;
        side_next.sb = s12p;
        side_next.sc = s20m;
      end
      PIV_Z: begin
        side_next.sa = s20p;
        side_next.sb = s12p;
        side_next.sc = s01m;
      end
      default: begin
        side_next.sa = s12m;
        side_next.sb = s20m;
        side_next.sc = s01m;
      end
    endcase
    if (tp[TW-1]) n_next = '0;
    else n_next = {tp[NW-13:0], 12'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else out_vld <= in_vld;
    n <= n_next;
    side <= side_next;
  end
endmodule

@@ src/rmq_sqrt.sv @@
module rmq_sqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_vld,
  input  logic [rmq_pkg::NW-1:0]  n,
  input  rmq_pkg::rmq_side_t      in_side,
  output logic                    out_vld,
  output logic [rmq_pkg::RW-1:0]  root,
  output logic [rmq_pkg::RW+1:0]  rem,
  output rmq_pkg::rmq_side_t      out_side
);
  import rmq_pkg::*;

  logic            vld  [1:RW];
  logic [NW-1:0]   nn   [1:RW];
  logic [RW-1:0]   rt   [1:RW];
  logic [RW+1:0]   rm   [1:RW];
  rmq_side_t       sd   [1:RW];

  logic            s_vld [0:RW-1];
  logic [NW-1:0]   s_nn  [0:RW-1];
  logic [RW-1:0]   s_rt  [0:RW-1];
  logic [RW+1:0]   s_rm  [0:RW-1];
  rmq_side_t       s_sd  [0:RW-1];
  logic [RW+3:0]   r4    [0:RW-1];
  logic [RW+3:0]   trial [0:RW-1];
  logic            win   [0:RW-1];

  always_comb begin
    s_vld[0] = in_vld;
    s_nn[0]  = n;
    s_rt[0]  = '0;
    s_rm[0]  = '0;
    s_sd[0]  = in_side;
    for (int k = 1; k < RW; k++) begin
      s_vld[k] = vld[k];
      s_nn[k]  = nn[k];
      s_rt[k]  = rt[k];
      s_rm[k]  = rm[k];
      s_sd[k]  = sd[k];
    end
    for (int k = 0; k < RW; k++) begin
      r4[k]    = {s_rm[k], s_nn[k][NW-1:NW-2]};
      trial[k] = {2'b00, s_rt[k], 2'b01};
      win[k]   = r4[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RW; k++) begin
      if (rst) vld[k+1] <= 1'b0;
      else vld[k+1] <= s_vld[k];
      nn[k+1] <= {s_nn[k][NW-3:0], 2'b00};
      rt[k+1] <= {s_rt[k][RW-2:0], win[k]};
      if (win[k]) rm[k+1] <= (RW+2)'(r4[k] - trial[k]);
      else rm[k+1] <= r4[k][RW+1:0];
      sd[k+1] <= s_sd[k];
    end
  end

  assign out_vld  = vld[RW];
  assign root     = rt[RW];
  assign rem      = rm[RW];
  assign out_side = sd[RW];
endmodule

@@ src/rmq_div.sv @@
module rmq_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_vld,
  input  logic [rmq_pkg::RW-1:0]  root,
  input  logic [rmq_pkg::RW+1:0]  rem,
  input  rmq_pkg::rmq_side_t      in_side,
  output logic                    out_vld,
  output rmq_pkg::rmq_dres_t      dres
);
  import rmq_pkg::*;

  logic [MW-1:0]   v_in;
  logic [SW-1:0]   mag  [0:2];
  logic [DW-1:0]   dd_in [0:2];
  logic signed [SW-1:0] sv [0:2];

  logic            p_vld;
  logic [DW-1:0]   p_dd [0:2];
  logic            p_neg [0:2];
  logic [MW-1:0]   p_v;
  logic [1:0]      p_piv;
  logic            p_deg;

  logic            vld  [1:QW];
  logic [MW-1:0]   rr   [1:QW][0:2];
  logic [QW-1:0]   qq   [1:QW][0:2];
  logic            ng   [1:QW][0:2];
  logic [MW-1:0]   vv   [1:QW];
  logic [1:0]      pv   [1:QW];
  logic            dg   [1:QW];

  logic            s_vld [0:QW-1];
  logic [MW-1:0]   s_rr  [0:QW-1][0:2];
  logic [QW-1:0]   s_qq  [0:QW-1][0:2];
  logic            s_ng  [0:QW-1][0:2];
  logic [MW-1:0]   s_vv  [0:QW-1];
  logic [1:0]      s_pv  [0:QW-1];
  logic            s_dg  [0:QW-1];
  logic [MW:0]     tr    [0:QW-1][0:2];
  logic            ge    [0:QW-1][0:2];
  logic signed [MW-1:0] qs [0:2];
  logic [QW-1:0]   qf;

  always_comb begin
    v_in = MW'(root) + MW'(rem > (RW+2)'(root));
    sv[0] = in_side.sa;
    sv[1] = in_side.sb;
    sv[2] = in_side.sc;
    for (int l = 0; l < 3; l++) begin
      mag[l] = sv[l][SW-1] ? SW'(-sv[l]) : SW'(sv[l]);
      dd_in[l] = {mag[l][DW-13:0], 12'b0} + DW'(v_in >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) p_vld <= 1'b0;
    else p_vld <= in_vld;
    for (int l = 0; l < 3; l++) begin
      p_dd[l]  <= dd_in[l];
      p_neg[l] <= sv[l][SW-1];
    end
    p_v   <= v_in;
    p_piv <= in_side.pivot;
    p_deg <= in_side.degenerate;
  end

  always_comb begin
    s_vld[0] = p_vld;
    s_vv[0]  = p_v;
    s_pv[0]  = p_piv;
    s_dg[0]  = p_deg;
    for (int l = 0; l < 3; l++) begin
      s_rr[0][l] = MW'(p_dd[l][DW-1:QW]);
      s_qq[0][l] = p_dd[l][QW-1:0];
      s_ng[0][l] = p_neg[l];
    end
    for (int k = 1; k < QW; k++) begin
      s_vld[k] = vld[k];
      s_vv[k]  = vv[k];
      s_pv[k]  = pv[k];
      s_dg[k]  = dg[k];
      for (int l = 0; l < 3; l++) begin
        s_rr[k][l] = rr[k][l];
        s_qq[k][l] = qq[k][l];
        s_ng[k][l] = ng[k][l];
      end
    end
    for (int k = 0; k < QW; k++) begin
      for (int l = 0; l < 3; l++) begin
        tr[k][l] = {s_rr[k][l], s_qq[k][l][QW-1]};
        ge[k][l] = tr[k][l] >= {1'b0, s_vv[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (rst) vld[k+1] <= 1'b0;
      else vld[k+1] <= s_vld[k];
      vv[k+1] <= s_vv[k];
      pv[k+1] <= s_pv[k];
      dg[k+1] <= s_dg[k];
      for (int l = 0; l < 3; l++) begin
        if (ge[k][l]) rr[k+1][l] <= MW'(tr[k][l] - {1'b0, s_vv[k]});
        else rr[k+1][l] <= tr[k][l][MW-1:0];
        qq[k+1][l] <= {s_qq[k][l][QW-2:0], ge[k][l]};
        ng[k+1][l] <= s_ng[k][l];
      end
    end
  end

  always_comb begin
    qf = '0;
    for (int l = 0; l < 3; l++) begin
      qf = qq[QW][l];
      if (vv[QW] == '0) qs[l] = '0;
      else if (ng[QW][l]) begin
        if (qf >= QW'(32768)) qs[l] = -16'sd32768;
        else qs[l] = MW'(-qf);
      end else begin
        if (qf > QW'(32767)) qs[l] = 16'sd32767;
        else qs[l] = MW'(qf);
      end
    end
    dres.pivot      = pv[QW];
    dres.degenerate = dg[QW];
    dres.v          = vv[QW];
    dres.qa         = qs[0];
    dres.qb         = qs[1];
    dres.qc         = qs[2];
  end

  assign out_vld = vld[QW];
endmodule

@@ src/rotation_matrix_to_quaternion_unit.sv @@
// Rotation matrix to unit quaternion. A request (nine Q2.14 entries) is
// taken whenever start is high; busy stays low, so a new request may come
// every cycle. The result appears with a one-cycle done strobe after
// passing the pivot-term register, 15 square root stages (one result bit
// each), a rounding register, 17 divider stages (one quotient bit each,
// three lanes side by side) and the output register. Results leave in
// request order and cannot be held off.
module rotation_matrix_to_quaternion_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rmq_pkg::rmq_req_t req,
  output logic              done,
  output rmq_pkg::rmq_res_t res
);
  import rmq_pkg::*;

  logic      pv_vld;
  logic [NW-1:0] pv_n;
  rmq_side_t pv_side;
  logic      sq_vld;
  logic [RW-1:0] sq_root;
  logic [RW+1:0] sq_rem;
  rmq_side_t sq_side;
  logic      dv_vld;
  rmq_dres_t dv;
  rmq_res_t  res_next;

  assign busy = 1'b0;

  rmq_pivot u_pivot (
    .clk(clk), .rst(rst), .in_vld(start & ~busy), .req(req),
    .out_vld(pv_vld), .n(pv_n), .side(pv_side)
  );

  rmq_sqrt u_sqrt (
    .clk(clk), .rst(rst), .in_vld(pv_vld), .n(pv_n), .in_side(pv_side),
    .out_vld(sq_vld), .root(sq_root), .rem(sq_rem), .out_side(sq_side)
  );

  rmq_div u_div (
    .clk(clk), .rst(rst), .in_vld(sq_vld), .root(sq_root), .rem(sq_rem),
    .in_side(sq_side), .out_vld(dv_vld), .dres(dv)
  );

  always_comb begin
    res_next.pivot = dv.pivot;
    res_next.degenerate = dv.degenerate;
    unique case (dv.pivot)
      PIV_X: begin
        res_next.qx = dv.v;
        res_next.qy = dv.qa;
        res_next.qz = dv.qb;
        res_next.qw = dv.qc;
      end
      PIV_Y: begin
        res_next.qx = dv.qa;
        res_next.qy = dv.v;
        res_next.qz = dv.qb;
        res_next.qw = dv.qc;
      end
      PIV_Z: begin
        res_next.qx = dv.qa;
        res_next.qy = dv.qb;
        res_next.qz = dv.v;
        res_next.qw = dv.qc;
      end
      default: begin
        res_next.qx = dv.qa;
        res_next.qy = dv.qb;
        res_next.qz = dv.qc;
        res_next.qw = dv.v;
      end
    endcase
    if (dv.degenerate) begin
      res_next.qx = '0;
      res_next.qy = '0;
      res_next.qz = '0;
      res_next.qw = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= dv_vld;
    res <= res_next;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT)) else $error("result without request");

  a_no_degen: assert property (@(posedge clk) disable iff (rst)
    done |-> !res.degenerate) else $error("degenerate pivot term");

  a_pivot_pos: assert property (@(posedge clk) disable iff (rst)
    (done && res.pivot == PIV_W) |-> !res.qw[MW-1]) else $error("negative pivot");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    !busy) else $error("busy raised");
endmodule
